// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// leb_pkg
// Types and constants shared by the line editor buffer modules.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int ACT_W          = 4;
    localparam int CHAR_W         = 7;
    localparam int KIND_W         = 4;
    localparam int POS_W          = 6;
    localparam int CAP_W          = 7;
    localparam int LINE_DEPTH_DEF = 64;
    localparam int TAB_SPACES     = 4;
    localparam int TAB_CNT_W      = $clog2(TAB_SPACES);

    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;

    typedef enum logic [ACT_W-1:0] {
        A_CHAR      = 4'd0,
        A_ENTER     = 4'd1,
        A_BACKSPACE = 4'd2,
        A_LEFT      = 4'd3,
        A_RIGHT     = 4'd4,
        A_DELETE    = 4'd5,
        A_INSERT    = 4'd6,
        A_TAB       = 4'd7,
        A_CAD       = 4'd8
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        K_ECHO      = 4'd0,
        K_BACKSPACE = 4'd1,
        K_LEFT      = 4'd2,
        K_RIGHT     = 4'd3,
        K_DELETE    = 4'd4,
        K_INSERT    = 4'd5,
        K_LINECHAR  = 4'd6,
        K_LINEEND   = 4'd7,
        K_RESETREQ  = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAB,
        S_STREAM,
        S_END
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_OVERWRITE,
        OP_REMOVE
    } t_cell_op;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] key_char;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [CHAR_W-1:0] out_char;
        logic [POS_W-1:0]  line_length;
        logic              last;
    } t_out_beat;

    // Command broadcast to every cell of the row in the same cycle.
    typedef struct packed {
        t_cell_op          op;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
    } t_cell_cmd;

endpackage

// ===== rtl/leb_cell.sv =====
// ----------------------------------------------------------------------------
// leb_cell
// One character position of the line; takes a new character or a neighbor's.
// ----------------------------------------------------------------------------
module leb_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                        i_clk,
    input  leb_pkg::t_cell_cmd          i_cmd,
    input  logic [leb_pkg::CHAR_W-1:0]  i_left,
    input  logic [leb_pkg::CHAR_W-1:0]  i_right,
    output logic [leb_pkg::CHAR_W-1:0]  o_char
);
    import leb_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_INDEX);

    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;

    always_comb begin
        n_char = r_char;
        unique case (i_cmd.op)
            OP_HOLD: begin
                n_char = r_char;
            end
            OP_INSERT: begin
                // Cells right of the cursor move one place to the right.
                if (MY_POS == i_cmd.pos) begin
                    n_char = i_cmd.ch;
                end else if (MY_POS > i_cmd.pos) begin
                    n_char = i_left;
                end
            end
            OP_OVERWRITE: begin
                if (MY_POS == i_cmd.pos) begin
                    n_char = i_cmd.ch;
                end
            end
            OP_REMOVE: begin
                if (MY_POS >= i_cmd.pos) begin
                    n_char = i_right;
                end
            end
            default: begin
                n_char = r_char;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

// ===== rtl/line_editor_buffer_core.sv =====
// ----------------------------------------------------------------------------
// line_editor_buffer_core
// Key-driven line editor: keeps a line, a cursor and an insert flag in a row
// of character cells and emits display and line beats.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   --------  ---------  -------------------------  ------------------------
//   in        input      i_in_valid / o_in_ready    i_in_data  (t_in_beat)
//   out       output     o_out_valid / i_out_ready  o_out_data (t_out_beat)
//   cfg       input      i_cfg_we                   i_cfg_data (capacity)
//
// One key is handled at a time. The key is taken in the idle state, and then
// each result beat is loaded while the output register can take it. Enter on
// a line of N characters yields N line character beats and a line end beat:
// the cell row shifts left one place per cycle while the output is free, and
// the head cell feeds the output. A key that yields no result returns to idle
// without waiting on the output. Reset is synchronous and active low; the
// line cells are not reset, since only positions below the line length are
// ever read. A stalled output holds the controller in a state with a beat due.
// ----------------------------------------------------------------------------
module line_editor_buffer_core #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  leb_pkg::t_in_beat          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output leb_pkg::t_out_beat         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [leb_pkg::CAP_W-1:0]  i_cfg_data
);
    import leb_pkg::*;

    localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(LINE_DEPTH);

    // Controller state.
    t_state              r_state, n_state;
    logic [ACT_W-1:0]    r_action, n_action;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [POS_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]    r_cursor, n_cursor;
    logic                r_insert, n_insert;
    logic [CAP_W-1:0]    r_cap;
    logic [TAB_CNT_W-1:0] r_tab_cnt, n_tab_cnt;
    logic [POS_W-1:0]    r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out, n_out;

    // Shared conditions.
    logic                in_accept;
    logic                out_free;
    logic [CAP_W-1:0]    cap_sat;
    logic [CAP_W-1:0]    limit;
    logic [CAP_W-1:0]    count_ext;
    logic                full;
    logic                next_full;
    logic                overwrite;
    logic                tab_last;
    logic                exec_has;
    logic                load;

    t_cell_cmd           w_cmd;
    logic [CHAR_W-1:0]   w_char [LINE_DEPTH];

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // Capacity above the row depth saturates; a capacity of zero accepts
    // nothing, otherwise typing stops at a length one below the capacity.
    assign cap_sat   = (r_cap > DEPTH_CAP) ? DEPTH_CAP : r_cap;
    assign limit     = (cap_sat == '0) ? '0 : cap_sat - CAP_W'(1);
    assign count_ext = CAP_W'(r_count);
    assign full      = count_ext >= limit;
    assign next_full = (count_ext + CAP_W'(1)) >= limit;
    assign overwrite = !r_insert && (r_cursor < r_count);

    // A character key yields at most one echo. A tab stops after four spaces or
    // before the first space that would be refused; an overwrite leaves the
    // length alone, so it can never cause the next refusal.
    assign tab_last = (r_action != A_TAB)
                   || (r_tab_cnt == TAB_CNT_W'(TAB_SPACES - 1))
                   || (!overwrite && next_full);

    // Whether a single-result key actually does something.
    always_comb begin
        exec_has = 1'b0;
        unique case (r_action)
            A_BACKSPACE, A_LEFT: exec_has = (r_cursor != '0);
            A_RIGHT, A_DELETE:   exec_has = (r_cursor < r_count);
            A_INSERT, A_CAD:     exec_has = 1'b1;
            default:             exec_has = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_in_data.action)
                        A_CHAR:  n_state = (i_in_data.key_char != '0) ? S_TAB : S_IDLE;
                        A_TAB:   n_state = S_TAB;
                        A_ENTER: n_state = (r_count == '0) ? S_END : S_STREAM;
                        A_BACKSPACE, A_LEFT, A_RIGHT, A_DELETE, A_INSERT, A_CAD: begin
                            n_state = S_EXEC;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                if (!exec_has || out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TAB: begin
                priority if (full) begin
                    n_state = S_IDLE;
                end else if (out_free && tab_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = r_state;
                end
            end
            S_STREAM: begin
                if (out_free && (r_idx == r_count - POS_W'(1))) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, cell commands and result beats.
    always_comb begin
        n_action  = r_action;
        n_char    = r_char;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_insert  = r_insert;
        n_tab_cnt = r_tab_cnt;
        n_idx     = r_idx;
        w_cmd     = '{op: OP_HOLD, pos: '0, ch: '0};
        load      = 1'b0;
        n_out     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_action  = i_in_data.action;
                    n_char    = i_in_data.key_char;
                    n_tab_cnt = '0;
                    n_idx     = '0;
                end
            end
            S_EXEC: begin
                if (exec_has && out_free) begin
                    load = 1'b1;
                    n_out.last = 1'b1;
                    unique case (r_action)
                        A_BACKSPACE: begin
                            w_cmd.op  = OP_REMOVE;
                            w_cmd.pos = r_cursor - POS_W'(1);
                            n_count   = r_count - POS_W'(1);
                            n_cursor  = r_cursor - POS_W'(1);
                            n_out.result_kind = K_BACKSPACE;
                        end
                        A_LEFT: begin
                            n_cursor = r_cursor - POS_W'(1);
                            n_out.result_kind = K_LEFT;
                        end
                        A_RIGHT: begin
                            n_cursor = r_cursor + POS_W'(1);
                            n_out.result_kind = K_RIGHT;
                        end
                        A_DELETE: begin
                            w_cmd.op  = OP_REMOVE;
                            w_cmd.pos = r_cursor;
                            n_count   = r_count - POS_W'(1);
                            n_out.result_kind = K_DELETE;
                        end
                        A_INSERT: begin
                            n_insert = !r_insert;
                            n_out.result_kind = K_INSERT;
                        end
                        default: begin
                            n_out.result_kind = K_RESETREQ;
                        end
                    endcase
                end
            end
            S_TAB: begin
                if (!full && out_free) begin
                    load      = 1'b1;
                    w_cmd.pos = r_cursor;
                    w_cmd.ch  = (r_action == A_TAB) ? SPACE_CHAR : r_char;
                    n_cursor  = r_cursor + POS_W'(1);
                    n_tab_cnt = r_tab_cnt + TAB_CNT_W'(1);
                    if (overwrite) begin
                        w_cmd.op = OP_OVERWRITE;
                    end else begin
                        w_cmd.op = OP_INSERT;
                        n_count  = r_count + POS_W'(1);
                    end
                    n_out.result_kind = K_ECHO;
                    n_out.out_char    = w_cmd.ch;
                    n_out.last        = tab_last;
                end
            end
            S_STREAM: begin
                // Shift the whole row left; the head cell leaves each cycle the output is free.
                if (out_free) begin
                    load      = 1'b1;
                    w_cmd.op  = OP_REMOVE;
                    w_cmd.pos = '0;
                    n_idx     = r_idx + POS_W'(1);
                    n_out.result_kind = K_LINECHAR;
                    n_out.out_char    = w_char[0];
                end
            end
            S_END: begin
                if (out_free) begin
                    load     = 1'b1;
                    n_count  = '0;
                    n_cursor = '0;
                    n_insert = 1'b1;
                    n_out.result_kind = K_LINEEND;
                    n_out.line_length = r_count;
                    n_out.last        = 1'b1;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_insert    <= 1'b1;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_insert    <= n_insert;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_char    <= n_char;
        r_tab_cnt <= n_tab_cnt;
        r_idx     <= n_idx;
        if (load) begin
            r_out <= n_out;
        end
    end

    // The row of character cells. The edge cells feed back their own value.
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        logic [CHAR_W-1:0] w_left;
        logic [CHAR_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_char[g];
        end else begin : g_body
            assign w_left = w_char[g-1];
        end

        if (g == LINE_DEPTH - 1) begin : g_tail
            assign w_right = w_char[g];
        end else begin : g_inner
            assign w_right = w_char[g+1];
        end

        leb_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_char  (w_char[g])
        );
    end

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid && i_rst_n;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/leb_checker.sv =====
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks on the line editor buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module leb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input leb_pkg::t_in_beat   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input leb_pkg::t_out_beat  o_out_data
);
    import leb_pkg::*;

    logic in_beat;
    logic out_stall;

    // A key that does work; a zero character and unused codes are dropped
    // in the idle state without leaving it.
    assign in_beat   = i_in_valid && o_in_ready && (i_in_data.action <= A_CAD) &&
                       !(i_in_data.action == A_CHAR && i_in_data.key_char == '0);
    assign out_stall = o_out_valid && !i_out_ready;

    // A stalled result beat stays offered.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)

    // Only one key is in work at a time.
    `ASSERT_NEXT(a_one_key, i_clk, i_rst_n, in_beat, !o_in_ready)

    // The length field is used only by the line end beat, which closes a key.
    `ASSERT_SAME(a_len_only_end, i_clk, i_rst_n,
        o_out_valid && o_out_data.result_kind != K_LINEEND, o_out_data.line_length == '0)
    `ASSERT_SAME(a_end_last, i_clk, i_rst_n,
        o_out_valid && o_out_data.result_kind == K_LINEEND, o_out_data.last)

    // Characters travel only on echo and line character beats.
    `ASSERT_SAME(a_char_kinds, i_clk, i_rst_n,
        o_out_valid && o_out_data.result_kind != K_ECHO &&
        o_out_data.result_kind != K_LINECHAR, o_out_data.out_char == '0)

endmodule

bind line_editor_buffer_core leb_checker u_leb_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_editor_buffer_core. Key beats go in over the
// input channel, and a line model inside the bench predicts every display and
// line beat. Each output beat is compared field by field with the oldest
// prediction. The run steps through several capacity settings and through
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import leb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 12;
    localparam int FILL_KEYS     = 64;
    localparam int FILL_PHASE    = 4;
    localparam int FIRST_UNUSED  = int'(A_CAD) + 1;
    localparam int LAST_UNUSED   = (1 << ACT_W) - 1;
    localparam int MAX_CHAR      = (1 << CHAR_W) - 1;
    localparam int MAX_CAP       = (1 << CAP_W) - 1;

    // ------------------------------------------------------------------------
    // Line model: keeps its own copy of the line, the cursor, the insert flag
    // and the capacity, and queues the beats that each key should produce.
    // ------------------------------------------------------------------------
    class edit_tracker;
        logic [CHAR_W-1:0] cells [LINE_DEPTH_DEF];
        int unsigned       count;
        int unsigned       cursor;
        bit                insert_on;
        int unsigned       capacity;
        t_out_beat         pending_beats [$];
        int unsigned       errors;

        function new();
            count     = 0;
            cursor    = 0;
            insert_on = 1'b1;
            capacity  = int'(CAP_RESET);
            errors    = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = int'(value);
        endfunction

        function void push_beat(t_kind kind, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] len);
            t_out_beat b;
            b.result_kind = kind;
            b.out_char    = ch;
            b.line_length = len;
            b.last        = 1'b0;
            pending_beats.push_back(b);
        endfunction

        // Returns 1 when the character went into the line.
        function bit take_char(logic [CHAR_W-1:0] ch);
            int unsigned lim;
            int unsigned i;
            lim = (capacity > LINE_DEPTH_DEF) ? LINE_DEPTH_DEF : capacity;
            lim = (lim == 0) ? 0 : lim - 1;
            if (count >= lim)
                return 1'b0;
            if (!insert_on && cursor < count) begin
                cells[cursor] = ch;
                cursor++;
                return 1'b1;
            end
            for (i = count; i > cursor; i--)
                cells[i] = cells[i-1];
            cells[cursor] = ch;
            count++;
            cursor++;
            return 1'b1;
        endfunction

        function void remove_at(int unsigned pos);
            int unsigned i;
            for (i = pos + 1; i < count; i++)
                cells[i-1] = cells[i];
            count--;
        endfunction

        function void note_key(t_in_beat key);
            int unsigned start;
            int unsigned i;
            start = pending_beats.size();
            case (key.action)
                A_CHAR: begin
                    if (key.key_char != '0 && take_char(key.key_char))
                        push_beat(K_ECHO, key.key_char, '0);
                end
                A_ENTER: begin
                    for (i = 0; i < count; i++)
                        push_beat(K_LINECHAR, cells[i], '0);
                    push_beat(K_LINEEND, '0, POS_W'(count));
                    count     = 0;
                    cursor    = 0;
                    insert_on = 1'b1;
                end
                A_BACKSPACE: begin
                    if (cursor > 0) begin
                        remove_at(cursor - 1);
                        cursor--;
                        push_beat(K_BACKSPACE, '0, '0);
                    end
                end
                A_LEFT: begin
                    if (cursor > 0) begin
                        cursor--;
                        push_beat(K_LEFT, '0, '0);
                    end
                end
                A_RIGHT: begin
                    if (cursor < count) begin
                        cursor++;
                        push_beat(K_RIGHT, '0, '0);
                    end
                end
                A_DELETE: begin
                    if (cursor < count) begin
                        remove_at(cursor);
                        push_beat(K_DELETE, '0, '0);
                    end
                end
                A_INSERT: begin
                    insert_on = !insert_on;
                    push_beat(K_INSERT, '0, '0);
                end
                A_TAB: begin
                    for (i = 0; i < TAB_SPACES; i++) begin
                        if (!take_char(SPACE_CHAR))
                            break;
                        push_beat(K_ECHO, SPACE_CHAR, '0);
                    end
                end
                A_CAD: begin
                    push_beat(K_RESETREQ, '0, '0);
                end
                default: ;
            endcase
            if (pending_beats.size() > start)
                pending_beats[pending_beats.size()-1].last = 1'b1;
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: result_kind %0d out_char %h line_length %0d last %0b",
                       got.result_kind, got.out_char, got.line_length, got.last);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
                errors++;
            end
            if (got.out_char !== want.out_char) begin
                $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
                errors++;
            end
            if (got.line_length !== want.line_length) begin
                $error("line_length: expected %0d, actual %0d",
                       want.line_length, got.line_length);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that drive the block. Every input starts
    // at a known value so nothing is undefined while reset is held.
    // ------------------------------------------------------------------------
    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_beat          in_data  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_beat         out_data;
    logic              cfg_we   = 1'b0;
    logic [CAP_W-1:0]  cfg_data = '0;

    edit_tracker tracker = new();
    t_in_beat    typed_keys [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    line_editor_buffer_core #(
        .LINE_DEPTH (LINE_DEPTH_DEF)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Output side. Signals are read at the rising edge before the block's own
    // updates land, so the handshake seen here is the one the block saw. The
    // ready line is redrawn every cycle from the current stall rate.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            tracker.check_beat(out_data);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a hang or a lost beat ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout with %0d beats still expected", tracker.pending_beats.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Key generation.
    // ------------------------------------------------------------------------
    function automatic t_in_beat make_key(t_action act, logic [CHAR_W-1:0] ch);
        t_in_beat k;
        k.action   = act;
        k.key_char = ch;
        return k;
    endfunction

    // Mostly printable typing with edits sprinkled in; enter_pct sets how
    // often a line is closed, which decides how long lines grow.
    function automatic t_in_beat random_key(int unsigned enter_pct);
        t_in_beat    k;
        int unsigned r;
        k.key_char = CHAR_W'($urandom);
        r = $urandom_range(99);
        if (r < enter_pct) begin
            k.action = A_ENTER;
        end else begin
            r = $urandom_range(99);
            if (r < 56) begin
                k.action = A_CHAR;
                if ($urandom_range(29) == 0)
                    k.key_char = '0;
            end else if (r < 63) begin
                k.action = A_BACKSPACE;
            end else if (r < 71) begin
                k.action = A_LEFT;
            end else if (r < 77) begin
                k.action = A_RIGHT;
            end else if (r < 82) begin
                k.action = A_DELETE;
            end else if (r < 86) begin
                k.action = A_INSERT;
            end else if (r < 92) begin
                k.action = A_TAB;
            end else if (r < 95) begin
                k.action = A_CAD;
            end else begin
                k.action = ACT_W'($urandom_range(LAST_UNUSED, FIRST_UNUSED));
            end
        end
        return k;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Each queued key is presented and held until the block takes
    // it. Valid is only changed once per edge: after a beat is taken it is
    // either reloaded with the next key or dropped for a gap. Now and then the
    // sender stops until every predicted beat has come back.
    // ------------------------------------------------------------------------
    task automatic drive_keys();
        t_in_beat beat;
        while (typed_keys.size() > 0) begin
            beat = typed_keys.pop_front();
            if ($urandom_range(49) == 0) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (tracker.pending_beats.size() != 0);
            end else if ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
            end
            in_valid <= 1'b1;
            in_data  <= beat;
            do @(posedge clk); while (!in_ready);
            tracker.note_key(beat);
        end
        in_valid <= 1'b0;
    endtask

    // Waits until every predicted beat has arrived, then lets a key that
    // produced nothing finish its cycle in the block.
    task automatic wait_drained();
        while (tracker.pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tracker.set_capacity(value);
    endtask

    // ------------------------------------------------------------------------
    // Capacity plan per phase. The second phase lowers the capacity below a
    // line that is already long; zero refuses everything; a capacity above
    // the row depth saturates, and the first such phase types enough to hit
    // the full row. The last setting is drawn at random.
    // ------------------------------------------------------------------------
    int unsigned phase_cap   [PHASES] = '{64, 3, 1, 0, 127, 2, 100, 65, 17, 40, 63, 0};
    int unsigned phase_keys  [PHASES] = '{25, 20, 20, 20, 20, 20, 25, 25, 25, 25, 25, 26};
    int unsigned phase_enter [PHASES] = '{5, 8, 10, 10, 0, 10, 6, 6, 6, 6, 6, 6};

    initial begin
        int unsigned p;
        int unsigned n;
        phase_cap[PHASES-1] = $urandom_range(MAX_CAP, 1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset capacity: field extremes, the ignored
        // cases at both ends of the line, overwrite inside and at the end of
        // the line, a tab, unused codes, ctrl-alt-del and an empty enter.
        send_idle_pct  = 27;
        recv_stall_pct = 60;
        typed_keys.push_back(make_key(A_CHAR, CHAR_W'(MAX_CHAR)));
        typed_keys.push_back(make_key(A_CHAR, CHAR_W'(1)));
        typed_keys.push_back(make_key(A_CHAR, '0));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_BACKSPACE, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_RIGHT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_RIGHT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_RIGHT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_DELETE, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_INSERT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_CHAR, CHAR_W'("Z")));
        typed_keys.push_back(make_key(A_CHAR, CHAR_W'("q")));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_LEFT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_DELETE, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_INSERT, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_TAB, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_BACKSPACE, CHAR_W'($urandom)));
        typed_keys.push_back(t_in_beat'{action: ACT_W'(FIRST_UNUSED),
                                        key_char: CHAR_W'($urandom)});
        typed_keys.push_back(t_in_beat'{action: ACT_W'(LAST_UNUSED),
                                        key_char: CHAR_W'($urandom)});
        typed_keys.push_back(make_key(A_CAD, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_ENTER, CHAR_W'($urandom)));
        typed_keys.push_back(make_key(A_ENTER, CHAR_W'($urandom)));
        drive_keys();

        // Random phases. The first third stalls mostly on the receiver, the
        // next mostly on the sender, the last runs with no idling at all.
        for (p = 0; p < PHASES; p++) begin
            case (p / 4)
                0: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 60;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 27;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            wait_drained();
            write_capacity(CAP_W'(phase_cap[p]));
            if (p == FILL_PHASE) begin
                for (n = 0; n < FILL_KEYS; n++)
                    typed_keys.push_back(make_key(A_CHAR, CHAR_W'($urandom_range(MAX_CHAR, 1))));
            end
            for (n = 0; n < phase_keys[p]; n++)
                typed_keys.push_back(random_key(phase_enter[p]));
            // Leave a long open line behind so the next, smaller capacity
            // starts below the current length.
            if (p == 0) begin
                for (n = 0; n < 12; n++)
                    typed_keys.push_back(make_key(A_CHAR, CHAR_W'($urandom_range(MAX_CHAR, 1))));
            end
            drive_keys();
        end

        // Close the last line so its contents are streamed and checked.
        typed_keys.push_back(make_key(A_ENTER, CHAR_W'($urandom)));
        drive_keys();
        wait_drained();

        if (tracker.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== line_editor_buffer_core.f =====
+incdir+rtl
rtl/leb_pkg.sv
rtl/leb_cell.sv
rtl/line_editor_buffer_core.sv
rtl/leb_checker.sv
bench/testbench.sv
